// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level core file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== src/c65_pkg.sv =====
// Types, constants and the opcode decoder of the 6502-subset core.
`default_nettype none
package c65_pkg;

	localparam int RAM_BYTES_DEF = 2048;
	localparam int IO_BYTES_DEF  = 32;
	localparam int ROM_BYTES_DEF = 32768;

	localparam logic [7:0]  SP_RESET     = 8'hFD;
	localparam logic [7:0]  P_RESET      = 8'h24;
	localparam logic [15:0] VEC_LO       = 16'hFFFC;
	localparam logic [15:0] VEC_HI       = 16'hFFFD;
	localparam logic [7:0]  STACK_PAGE   = 8'h01;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_EXEC  = 2'd2;
	localparam logic [1:0] MODE_RESET = 2'd3;

	localparam logic [1:0] RG_NONE = 2'd0;
	localparam logic [1:0] RG_RAM  = 2'd1;
	localparam logic [1:0] RG_IO   = 2'd2;
	localparam logic [1:0] RG_ROM  = 2'd3;

	// addressing modes
	localparam logic [3:0] AM_IMP = 4'd0;
	localparam logic [3:0] AM_IMM = 4'd1;
	localparam logic [3:0] AM_ZP  = 4'd2;
	localparam logic [3:0] AM_ZPX = 4'd3;
	localparam logic [3:0] AM_ZPY = 4'd4;
	localparam logic [3:0] AM_ABS = 4'd5;
	localparam logic [3:0] AM_ABX = 4'd6;
	localparam logic [3:0] AM_ABY = 4'd7;
	localparam logic [3:0] AM_INX = 4'd8;
	localparam logic [3:0] AM_INY = 4'd9;
	localparam logic [3:0] AM_REL = 4'd10;
	localparam logic [3:0] AM_IND = 4'd11;

	// instruction kinds
	localparam logic [3:0] K_NOP  = 4'd0;
	localparam logic [3:0] K_DATA = 4'd1;
	localparam logic [3:0] K_ST   = 4'd2;
	localparam logic [3:0] K_RMW  = 4'd3;
	localparam logic [3:0] K_PHA  = 4'd4;
	localparam logic [3:0] K_PHP  = 4'd5;
	localparam logic [3:0] K_PLA  = 4'd6;
	localparam logic [3:0] K_PLP  = 4'd7;
	localparam logic [3:0] K_RTS  = 4'd8;
	localparam logic [3:0] K_RTI  = 4'd9;
	localparam logic [3:0] K_JSR  = 4'd10;
	localparam logic [3:0] K_JMP  = 4'd11;
	localparam logic [3:0] K_BR   = 4'd12;
	localparam logic [3:0] K_FLG  = 4'd13;
	localparam logic [3:0] K_TXS  = 4'd14;
	localparam logic [3:0] K_BRK  = 4'd15;

	// shared unit functions
	localparam logic [3:0] FN_ADC = 4'd0;
	localparam logic [3:0] FN_SBC = 4'd1;
	localparam logic [3:0] FN_AND = 4'd2;
	localparam logic [3:0] FN_ORA = 4'd3;
	localparam logic [3:0] FN_EOR = 4'd4;
	localparam logic [3:0] FN_CMP = 4'd5;
	localparam logic [3:0] FN_BIT = 4'd6;
	localparam logic [3:0] FN_ASL = 4'd7;
	localparam logic [3:0] FN_LSR = 4'd8;
	localparam logic [3:0] FN_ROL = 4'd9;
	localparam logic [3:0] FN_ROR = 4'd10;
	localparam logic [3:0] FN_INC = 4'd11;
	localparam logic [3:0] FN_DEC = 4'd12;
	localparam logic [3:0] FN_PSA = 4'd13;
	localparam logic [3:0] FN_LDB = 4'd14;

	// register selects
	localparam logic [1:0] R_A  = 2'd0;
	localparam logic [1:0] R_X  = 2'd1;
	localparam logic [1:0] R_Y  = 2'd2;
	localparam logic [1:0] R_SP = 2'd3;
	localparam logic [1:0] R_NONE = 2'd3;

	// status bit positions
	localparam logic [2:0] FB_C = 3'd0;
	localparam logic [2:0] FB_Z = 3'd1;
	localparam logic [2:0] FB_I = 3'd2;
	localparam logic [2:0] FB_D = 3'd3;
	localparam logic [2:0] FB_B = 3'd4;
	localparam logic [2:0] FB_V = 3'd6;
	localparam logic [2:0] FB_N = 3'd7;

	typedef struct packed {
		logic [3:0] am;
		logic [3:0] kind;
		logic [3:0] fn;
		logic [1:0] src;
		logic [1:0] dst;
		logic [2:0] bidx;
		logic       bval;
		logic       known;
	} dec_t;

	typedef struct packed {
		logic [3:0] fn;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] p;
	} alu_req_t;

	typedef struct packed {
		logic [7:0] res;
		logic [7:0] p;
	} alu_rsp_t;

	typedef struct packed {
		logic        en;
		logic        we;
		logic [15:0] addr;
		logic [7:0]  wdata;
	} mem_req_t;

	function automatic dec_t mk(input logic [3:0] am, input logic [3:0] kind,
			input logic [3:0] fn, input logic [1:0] src, input logic [1:0] dst,
			input logic [2:0] bidx, input logic bval);
		dec_t d;
		d.am = am; d.kind = kind; d.fn = fn; d.src = src; d.dst = dst;
		d.bidx = bidx; d.bval = bval; d.known = 1'b1;
		return d;
	endfunction

	function automatic dec_t c65_decode(input logic [7:0] op);
		dec_t d;
		d = mk(AM_IMP, K_NOP, FN_PSA, R_A, R_NONE, FB_C, 1'b0);
		d.known = 1'b0;
		unique case (op)
			8'hA9: d = mk(AM_IMM, K_DATA, FN_LDB, R_A, R_A, FB_C, 1'b0);
			8'hA5: d = mk(AM_ZP,  K_DATA, FN_LDB, R_A, R_A, FB_C, 1'b0);
			8'hB5: d = mk(AM_ZPX, K_DATA, FN_LDB, R_A, R_A, FB_C, 1'b0);
			8'hAD: d = mk(AM_ABS, K_DATA, FN_LDB, R_A, R_A, FB_C, 1'b0);
			8'hBD: d = mk(AM_ABX, K_DATA, FN_LDB, R_A, R_A, FB_C, 1'b0);
			8'hB9: d = mk(AM_ABY, K_DATA, FN_LDB, R_A, R_A, FB_C, 1'b0);
			8'hA1: d = mk(AM_INX, K_DATA, FN_LDB, R_A, R_A, FB_C, 1'b0);
			8'hB1: d = mk(AM_INY, K_DATA, FN_LDB, R_A, R_A, FB_C, 1'b0);
			8'hA2: d = mk(AM_IMM, K_DATA, FN_LDB, R_A, R_X, FB_C, 1'b0);
			8'hA6: d = mk(AM_ZP,  K_DATA, FN_LDB, R_A, R_X, FB_C, 1'b0);
			8'hB6: d = mk(AM_ZPY, K_DATA, FN_LDB, R_A, R_X, FB_C, 1'b0);
			8'hAE: d = mk(AM_ABS, K_DATA, FN_LDB, R_A, R_X, FB_C, 1'b0);
			8'hBE: d = mk(AM_ABY, K_DATA, FN_LDB, R_A, R_X, FB_C, 1'b0);
			8'hA0: d = mk(AM_IMM, K_DATA, FN_LDB, R_A, R_Y, FB_C, 1'b0);
			8'h85: d = mk(AM_ZP,  K_ST, FN_PSA, R_A, R_NONE, FB_C, 1'b0);
			8'h95: d = mk(AM_ZPX, K_ST, FN_PSA, R_A, R_NONE, FB_C, 1'b0);
			8'h8D: d = mk(AM_ABS, K_ST, FN_PSA, R_A, R_NONE, FB_C, 1'b0);
			8'h9D: d = mk(AM_ABX, K_ST, FN_PSA, R_A, R_NONE, FB_C, 1'b0);
			8'h99: d = mk(AM_ABY, K_ST, FN_PSA, R_A, R_NONE, FB_C, 1'b0);
			8'h81: d = mk(AM_INX, K_ST, FN_PSA, R_A, R_NONE, FB_C, 1'b0);
			8'h91: d = mk(AM_INY, K_ST, FN_PSA, R_A, R_NONE, FB_C, 1'b0);
			8'h86: d = mk(AM_ZP,  K_ST, FN_PSA, R_X, R_NONE, FB_C, 1'b0);
			8'h96: d = mk(AM_ZPY, K_ST, FN_PSA, R_X, R_NONE, FB_C, 1'b0);
			8'h8E: d = mk(AM_ABS, K_ST, FN_PSA, R_X, R_NONE, FB_C, 1'b0);
			8'h84: d = mk(AM_ZP,  K_ST, FN_PSA, R_Y, R_NONE, FB_C, 1'b0);
			8'h94: d = mk(AM_ZPX, K_ST, FN_PSA, R_Y, R_NONE, FB_C, 1'b0);
			8'h8C: d = mk(AM_ABS, K_ST, FN_PSA, R_Y, R_NONE, FB_C, 1'b0);
			8'h48: d = mk(AM_IMP, K_PHA, FN_PSA, R_A, R_NONE, FB_C, 1'b0);
			8'h68: d = mk(AM_IMP, K_PLA, FN_LDB, R_A, R_A, FB_C, 1'b0);
			8'h08: d = mk(AM_IMP, K_PHP, FN_PSA, R_A, R_NONE, FB_C, 1'b0);
			8'h28: d = mk(AM_IMP, K_PLP, FN_PSA, R_A, R_NONE, FB_C, 1'b0);
			8'h00: d = mk(AM_IMP, K_BRK, FN_PSA, R_A, R_NONE, FB_B, 1'b1);
			8'hEA: d = mk(AM_IMP, K_NOP, FN_PSA, R_A, R_NONE, FB_C, 1'b0);
			8'h20: d = mk(AM_ABS, K_JSR, FN_PSA, R_A, R_NONE, FB_C, 1'b0);
			8'h60: d = mk(AM_IMP, K_RTS, FN_PSA, R_A, R_NONE, FB_C, 1'b0);
			8'h40: d = mk(AM_IMP, K_RTI, FN_PSA, R_A, R_NONE, FB_C, 1'b0);
			8'h4C: d = mk(AM_ABS, K_JMP, FN_PSA, R_A, R_NONE, FB_C, 1'b0);
			8'h6C: d = mk(AM_IND, K_JMP, FN_PSA, R_A, R_NONE, FB_C, 1'b0);
			8'h29: d = mk(AM_IMM, K_DATA, FN_AND, R_A, R_A, FB_C, 1'b0);
			8'h09: d = mk(AM_IMM, K_DATA, FN_ORA, R_A, R_A, FB_C, 1'b0);
			8'h49: d = mk(AM_IMM, K_DATA, FN_EOR, R_A, R_A, FB_C, 1'b0);
			8'hC9: d = mk(AM_IMM, K_DATA, FN_CMP, R_A, R_NONE, FB_C, 1'b0);
			8'hE0: d = mk(AM_IMM, K_DATA, FN_CMP, R_X, R_NONE, FB_C, 1'b0);
			8'hC0: d = mk(AM_IMM, K_DATA, FN_CMP, R_Y, R_NONE, FB_C, 1'b0);
			8'h69: d = mk(AM_IMM, K_DATA, FN_ADC, R_A, R_A, FB_C, 1'b0);
			8'h61: d = mk(AM_INX, K_DATA, FN_ADC, R_A, R_A, FB_C, 1'b0);
			8'h71: d = mk(AM_INY, K_DATA, FN_ADC, R_A, R_A, FB_C, 1'b0);
			8'hE9: d = mk(AM_IMM, K_DATA, FN_SBC, R_A, R_A, FB_C, 1'b0);
			8'hE1: d = mk(AM_INX, K_DATA, FN_SBC, R_A, R_A, FB_C, 1'b0);
			8'hF1: d = mk(AM_INY, K_DATA, FN_SBC, R_A, R_A, FB_C, 1'b0);
			8'h24: d = mk(AM_ZP,  K_DATA, FN_BIT, R_A, R_NONE, FB_C, 1'b0);
			8'h2C: d = mk(AM_ABS, K_DATA, FN_BIT, R_A, R_NONE, FB_C, 1'b0);
			8'hAA: d = mk(AM_IMP, K_DATA, FN_PSA, R_A, R_X, FB_C, 1'b0);
			8'h8A: d = mk(AM_IMP, K_DATA, FN_PSA, R_X, R_A, FB_C, 1'b0);
			8'hA8: d = mk(AM_IMP, K_DATA, FN_PSA, R_A, R_Y, FB_C, 1'b0);
			8'h98: d = mk(AM_IMP, K_DATA, FN_PSA, R_Y, R_A, FB_C, 1'b0);
			8'hBA: d = mk(AM_IMP, K_DATA, FN_PSA, R_SP, R_X, FB_C, 1'b0);
			8'h9A: d = mk(AM_IMP, K_TXS, FN_PSA, R_X, R_NONE, FB_C, 1'b0);
			8'hCA: d = mk(AM_IMP, K_DATA, FN_DEC, R_X, R_X, FB_C, 1'b0);
			8'hE8: d = mk(AM_IMP, K_DATA, FN_INC, R_X, R_X, FB_C, 1'b0);
			8'h18: d = mk(AM_IMP, K_FLG, FN_PSA, R_A, R_NONE, FB_C, 1'b0);
			8'h38: d = mk(AM_IMP, K_FLG, FN_PSA, R_A, R_NONE, FB_C, 1'b1);
			8'hD8: d = mk(AM_IMP, K_FLG, FN_PSA, R_A, R_NONE, FB_D, 1'b0);
			8'hF8: d = mk(AM_IMP, K_FLG, FN_PSA, R_A, R_NONE, FB_D, 1'b1);
			8'h58: d = mk(AM_IMP, K_FLG, FN_PSA, R_A, R_NONE, FB_I, 1'b0);
			8'h78: d = mk(AM_IMP, K_FLG, FN_PSA, R_A, R_NONE, FB_I, 1'b1);
			8'hB8: d = mk(AM_IMP, K_FLG, FN_PSA, R_A, R_NONE, FB_V, 1'b0);
			8'h90: d = mk(AM_REL, K_BR, FN_PSA, R_A, R_NONE, FB_C, 1'b0);
			8'hB0: d = mk(AM_REL, K_BR, FN_PSA, R_A, R_NONE, FB_C, 1'b1);
			8'hD0: d = mk(AM_REL, K_BR, FN_PSA, R_A, R_NONE, FB_Z, 1'b0);
			8'hF0: d = mk(AM_REL, K_BR, FN_PSA, R_A, R_NONE, FB_Z, 1'b1);
			8'h10: d = mk(AM_REL, K_BR, FN_PSA, R_A, R_NONE, FB_N, 1'b0);
			8'h30: d = mk(AM_REL, K_BR, FN_PSA, R_A, R_NONE, FB_N, 1'b1);
			8'h50: d = mk(AM_REL, K_BR, FN_PSA, R_A, R_NONE, FB_V, 1'b0);
			8'h70: d = mk(AM_REL, K_BR, FN_PSA, R_A, R_NONE, FB_V, 1'b1);
			8'h0A: d = mk(AM_IMP, K_DATA, FN_ASL, R_A, R_A, FB_C, 1'b0);
			8'h4A: d = mk(AM_IMP, K_DATA, FN_LSR, R_A, R_A, FB_C, 1'b0);
			8'h2A: d = mk(AM_IMP, K_DATA, FN_ROL, R_A, R_A, FB_C, 1'b0);
			8'h6A: d = mk(AM_IMP, K_DATA, FN_ROR, R_A, R_A, FB_C, 1'b0);
			8'h06: d = mk(AM_ZP,  K_RMW, FN_ASL, R_A, R_NONE, FB_C, 1'b0);
			8'h26: d = mk(AM_ZP,  K_RMW, FN_ROL, R_A, R_NONE, FB_C, 1'b0);
			8'h66: d = mk(AM_ZP,  K_RMW, FN_ROR, R_A, R_NONE, FB_C, 1'b0);
			8'h76: d = mk(AM_ZPX, K_RMW, FN_ROR, R_A, R_NONE, FB_C, 1'b0);
			8'h6E: d = mk(AM_ABS, K_RMW, FN_ROR, R_A, R_NONE, FB_C, 1'b0);
			8'h7E: d = mk(AM_ABX, K_RMW, FN_ROR, R_A, R_NONE, FB_C, 1'b0);
			8'hE6: d = mk(AM_ZP,  K_RMW, FN_INC, R_A, R_NONE, FB_C, 1'b0);
			8'hF6: d = mk(AM_ZPX, K_RMW, FN_INC, R_A, R_NONE, FB_C, 1'b0);
			8'hEE: d = mk(AM_ABS, K_RMW, FN_INC, R_A, R_NONE, FB_C, 1'b0);
			8'hC6: d = mk(AM_ZP,  K_RMW, FN_DEC, R_A, R_NONE, FB_C, 1'b0);
			8'hD6: d = mk(AM_ZPX, K_RMW, FN_DEC, R_A, R_NONE, FB_C, 1'b0);
			8'hCE: d = mk(AM_ABS, K_RMW, FN_DEC, R_A, R_NONE, FB_C, 1'b0);
			default: ;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

// ===== src/c65_alu.sv =====
// Shared arithmetic, logic, compare and shift unit.
`default_nettype none
module c65_alu import c65_pkg::*; (
	input  alu_req_t req,
	output alu_rsp_t rsp
);
	logic [8:0] sum;
	logic [8:0] dif;
	logic [7:0] res;
	logic [7:0] p;
	logic       zn_en;

	always_comb begin
		sum   = {1'b0, req.a} + {1'b0, req.b} + {8'd0, req.p[FB_C]};
		dif   = {1'b0, req.a} - {1'b0, req.b} - {8'd0, ~req.p[FB_C]};
		res   = req.a;
		p     = req.p;
		zn_en = 1'b1;
		unique case (req.fn)
			FN_ADC: begin
				res = sum[7:0];
				p[FB_V] = (req.a[7] ^ sum[7]) & (req.b[7] ^ sum[7]);
				p[FB_C] = sum[8];
			end
			FN_SBC: begin
				res = dif[7:0];
				p[FB_V] = (req.a[7] ^ dif[7]) & (~req.b[7] ^ dif[7]);
				p[FB_C] = ~dif[8];
			end
			FN_AND: res = req.a & req.b;
			FN_ORA: res = req.a | req.b;
			FN_EOR: res = req.a ^ req.b;
			FN_CMP: begin
				res = req.a - req.b;
				p[FB_C] = (req.a >= req.b);
			end
			FN_BIT: begin
				zn_en = 1'b0;
				p[FB_Z] = ((req.a & req.b) == 8'd0);
				p[FB_V] = req.b[6];
				p[FB_N] = req.b[7];
			end
			FN_ASL: begin
				res = {req.a[6:0], 1'b0};
				p[FB_C] = req.a[7];
			end
			FN_LSR: begin
				res = {1'b0, req.a[7:1]};
				p[FB_C] = req.a[0];
			end
			FN_ROL: begin
				res = {req.a[6:0], req.p[FB_C]};
				p[FB_C] = req.a[7];
			end
			FN_ROR: begin
				res = {req.p[FB_C], req.a[7:1]};
				p[FB_C] = req.a[0];
			end
			FN_INC: res = req.a + 8'd1;
			FN_DEC: res = req.a - 8'd1;
			FN_PSA: res = req.a;
			FN_LDB: res = req.b;
			default: res = req.a;
		endcase
		if (zn_en) begin
			p[FB_Z] = (res == 8'd0);
			p[FB_N] = res[7];
		end
		rsp.res = res;
		rsp.p   = p;
	end
endmodule
`default_nettype wire

// ===== src/c65_mem.sv =====
// Memory map: mirrored work RAM with clearing pass, I/O registers, writable program ROM.
`default_nettype none
module c65_mem import c65_pkg::*; #(
	parameter int RAM_BYTES = RAM_BYTES_DEF,
	parameter int IO_BYTES  = IO_BYTES_DEF,
	parameter int ROM_BYTES = ROM_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  mem_req_t   req,
	output logic [7:0] rdata,
	output logic       busy
);
	localparam int RAM_AW = $clog2(RAM_BYTES);
	localparam int ROM_AW = $clog2(ROM_BYTES);
	localparam int IO_AW  = $clog2(IO_BYTES);

	logic [7:0] ram [RAM_BYTES];
	logic [7:0] rom [ROM_BYTES];
	logic [7:0] io_q [IO_BYTES];

	logic [RAM_AW-1:0] clr_q;
	logic              busy_q;
	logic [7:0]        ram_rd_q, rom_rd_q, io_rd_q;
	logic [1:0]        sel_q;
	logic              in_ram, in_io, in_rom;
	logic [1:0]        sel;
	logic [RAM_AW-1:0] ram_idx;
	logic [ROM_AW-1:0] rom_idx;
	logic [IO_AW-1:0]  io_idx;

	always_comb begin
		in_ram  = (req.addr[15:13] == 3'd0);
		in_io   = (req.addr[15:5] == 11'h200) && ({1'b0, req.addr[4:0]} < 6'(IO_BYTES));
		in_rom  = req.addr[15];
		ram_idx = busy_q ? clr_q : req.addr[RAM_AW-1:0];
		rom_idx = req.addr[ROM_AW-1:0];
		io_idx  = req.addr[IO_AW-1:0];
		priority if (in_ram) sel = RG_RAM;
		else if (in_io)      sel = RG_IO;
		else if (in_rom)     sel = RG_ROM;
		else                 sel = RG_NONE;
	end

	// sweep the RAM to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == RAM_AW'(RAM_BYTES - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) ram[ram_idx] <= 8'd0;
		else if (req.en && req.we && in_ram) ram[ram_idx] <= req.wdata;
		ram_rd_q <= ram[ram_idx];
	end

	always_ff @(posedge clk) begin
		if (req.en && req.we && in_rom) rom[rom_idx] <= req.wdata;
		rom_rd_q <= rom[rom_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < IO_BYTES; i++) io_q[i] <= 8'd0;
			io_rd_q <= 8'd0;
		end else begin
			if (req.en && req.we && in_io) io_q[io_idx] <= req.wdata;
			io_rd_q <= in_io ? io_q[io_idx] : 8'd0;
		end
	end

	always_ff @(posedge clk) begin
		sel_q <= sel;
	end

	always_comb begin
		unique case (sel_q)
			RG_RAM:  rdata = ram_rd_q;
			RG_IO:   rdata = io_rd_q;
			RG_ROM:  rdata = rom_rd_q;
			default: rdata = 8'd0;
		endcase
	end

	assign busy = busy_q;
endmodule
`default_nettype wire

// ===== src/cpu_6502_subset_core.sv =====
// Top level: sequencer around the shared ALU and the single-port memory map.
//
//  channel  | dir | tdata fields (lowest bit up)
//  s_axis   | in  | mode[1:0] bus_addr[17:2] bus_data[25:18] pad[31:26]
//  m_axis   | out | prog_counter accum index_x index_y stack_ptr flags read_data
//           |     | executed_opcode opcode_known, pad to 80 bits
//
// Bus writes, bus reads, reset and instructions each run as a sequence of states,
// with at most one memory access per cycle through the single memory port.
// After reset the work RAM is cleared to zero; no beat is taken then.
// A result beat waits in the output register; the next beat is taken once
// that register is loaded.
`default_nettype none
module cpu_6502_subset_core import c65_pkg::*; #(
	parameter int RAM_BYTES = RAM_BYTES_DEF,
	parameter int IO_BYTES  = IO_BYTES_DEF,
	parameter int ROM_BYTES = ROM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // mode, bus_addr, bus_data
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata   // prog_counter, accum, index_x, index_y, stack_ptr,
	                               // flags, read_data, executed_opcode, opcode_known
);
	`include "assert_macros.svh"

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_V0   = 4'd2;
	localparam logic [3:0] S_V1   = 4'd3;
	localparam logic [3:0] S_OP   = 4'd4;
	localparam logic [3:0] S_B1   = 4'd5;
	localparam logic [3:0] S_B2   = 4'd6;
	localparam logic [3:0] S_P0   = 4'd7;
	localparam logic [3:0] S_P1   = 4'd8;
	localparam logic [3:0] S_EA   = 4'd9;
	localparam logic [3:0] S_MEM  = 4'd10;
	localparam logic [3:0] S_JS   = 4'd11;
	localparam logic [3:0] S_J1   = 4'd12;
	localparam logic [3:0] S_PL   = 4'd13;
	localparam logic [3:0] S_PLL  = 4'd14;
	localparam logic [3:0] S_DONE = 4'd15;
	// the pull-high state shares the S_P0 code with the pointer and jump-vector reads
	localparam logic [3:0] S_PLH  = S_P0;

	logic [3:0]  state_q, state_d;
	logic        plh_q, plh_d;       // S_P0 code reused: set when pulling return high byte
	logic        j0_q, j0_d;         // S_P0 code reused: set when reading jump vector low byte
	logic [15:0] pc_q, pc_d, ea_q, ea_d;
	logic [7:0]  a_q, a_d, x_q, x_d, y_q, y_d, sp_q, sp_d, p_q, p_d;
	logic [7:0]  op_q, op_d, lo_q, lo_d, rdat_q, rdat_d, opc_q, opc_d;
	logic        known_q, known_d;
	logic        mv_q;
	logic [79:0] mdata_q;
	logic        load_out;

	mem_req_t    mreq;
	logic [7:0]  rdata;
	logic        mem_busy;
	alu_req_t    areq;
	alu_rsp_t    arsp;
	dec_t        dec;
	logic [1:0]  in_mode;
	logic [15:0] in_addr;
	logic [7:0]  in_data;
	logic [15:0] tgt;
	logic [15:0] ret;
	logic        accept;

	c65_mem #(.RAM_BYTES(RAM_BYTES), .IO_BYTES(IO_BYTES), .ROM_BYTES(ROM_BYTES)) u_mem (
		.clk(clk), .arst_n(arst_n), .req(mreq), .rdata(rdata), .busy(mem_busy)
	);

	c65_alu u_alu (.req(areq), .rsp(arsp));

	function automatic logic [7:0] regsel(input logic [1:0] s, input logic [7:0] a,
			input logic [7:0] x, input logic [7:0] y, input logic [7:0] sp);
		logic [7:0] r;
		unique case (s)
			R_A:     r = a;
			R_X:     r = x;
			R_Y:     r = y;
			default: r = sp;
		endcase
		return r;
	endfunction

	assign in_mode  = s_tdata[1:0];
	assign in_addr  = s_tdata[17:2];
	assign in_data  = s_tdata[25:18];
	assign s_tready = (state_q == S_IDLE) && !mem_busy;
	assign accept   = s_tvalid && s_tready;
	assign dec      = c65_decode((state_q == S_OP) ? rdata : op_q);
	assign tgt      = {rdata, lo_q};
	assign ret      = pc_q - 16'd1;

	always_comb begin
		state_d = state_q;
		plh_d = 1'b0; j0_d = 1'b0;
		pc_d = pc_q; ea_d = ea_q; a_d = a_q; x_d = x_q; y_d = y_q;
		sp_d = sp_q; p_d = p_q; op_d = op_q; lo_d = lo_q;
		rdat_d = rdat_q; opc_d = opc_q; known_d = known_q;
		mreq = '0;
		areq.fn = dec.fn;
		areq.a  = regsel(dec.src, a_q, x_q, y_q, sp_q);
		areq.b  = rdata;
		areq.p  = p_q;
		load_out = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					rdat_d = 8'd0; opc_d = 8'd0; known_d = 1'b0;
					unique case (in_mode)
						MODE_WRITE: begin
							mreq = '{en: 1'b1, we: 1'b1, addr: in_addr, wdata: in_data};
							state_d = S_DONE;
						end
						MODE_READ: begin
							mreq = '{en: 1'b1, we: 1'b0, addr: in_addr, wdata: 8'd0};
							state_d = S_RD;
						end
						MODE_EXEC: begin
							mreq = '{en: 1'b1, we: 1'b0, addr: pc_q, wdata: 8'd0};
							pc_d = pc_q + 16'd1;
							state_d = S_OP;
						end
						default: begin
							a_d = 8'd0; x_d = 8'd0; y_d = 8'd0;
							sp_d = SP_RESET; p_d = P_RESET;
							mreq = '{en: 1'b1, we: 1'b0, addr: VEC_LO, wdata: 8'd0};
							state_d = S_V0;
						end
					endcase
				end
			end
			S_RD: begin
				rdat_d = rdata;
				state_d = S_DONE;
			end
			S_V0: begin
				lo_d = rdata;
				mreq = '{en: 1'b1, we: 1'b0, addr: VEC_HI, wdata: 8'd0};
				state_d = S_V1;
			end
			S_V1: begin
				pc_d = tgt;
				state_d = S_DONE;
			end
			S_OP: begin
				op_d = rdata; opc_d = rdata; known_d = dec.known;
				state_d = S_DONE;
				if (dec.am != AM_IMP) begin
					mreq = '{en: 1'b1, we: 1'b0, addr: pc_q, wdata: 8'd0};
					pc_d = pc_q + 16'd1;
					state_d = S_B1;
				end else begin
					unique case (dec.kind)
						K_DATA: begin
							areq.a = regsel(dec.src, a_q, x_q, y_q, sp_q);
							p_d = arsp.p;
							unique case (dec.dst)
								R_A: a_d = arsp.res;
								R_X: x_d = arsp.res;
								R_Y: y_d = arsp.res;
								default: ;
							endcase
						end
						K_PHA, K_PHP: begin
							mreq = '{en: 1'b1, we: 1'b1, addr: {STACK_PAGE, sp_q},
								wdata: (dec.kind == K_PHA) ? a_q : p_q};
							sp_d = sp_q - 8'd1;
						end
						K_PLA, K_PLP, K_RTS, K_RTI: begin
							mreq = '{en: 1'b1, we: 1'b0, addr: {STACK_PAGE, sp_q + 8'd1},
								wdata: 8'd0};
							sp_d = sp_q + 8'd1;
							state_d = S_PL;
						end
						K_TXS: sp_d = x_q;
						K_FLG, K_BRK: p_d[dec.bidx] = dec.bval;
						default: ;
					endcase
				end
			end
			S_B1: begin
				state_d = S_DONE;
				unique case (dec.am)
					AM_IMM: begin
						p_d = arsp.p;
						unique case (dec.dst)
							R_A: a_d = arsp.res;
							R_X: x_d = arsp.res;
							R_Y: y_d = arsp.res;
							default: ;
						endcase
					end
					AM_REL: begin
						if (p_q[dec.bidx] == dec.bval)
							pc_d = pc_q + {{8{rdata[7]}}, rdata};
					end
					AM_ZP: begin
						ea_d = {8'd0, rdata};
						state_d = S_EA;
					end
					AM_ZPX: begin
						ea_d = {8'd0, rdata + x_q};
						state_d = S_EA;
					end
					AM_ZPY: begin
						ea_d = {8'd0, rdata + y_q};
						state_d = S_EA;
					end
					AM_INX, AM_INY: begin
						ea_d = {8'd0, (dec.am == AM_INX) ? rdata + x_q : rdata};
						mreq = '{en: 1'b1, we: 1'b0, addr: ea_d, wdata: 8'd0};
						state_d = S_P0;
					end
					default: begin
						// absolute forms, jumps, subroutine call: fetch high byte
						lo_d = rdata;
						mreq = '{en: 1'b1, we: 1'b0, addr: pc_q, wdata: 8'd0};
						pc_d = pc_q + 16'd1;
						state_d = S_B2;
					end
				endcase
			end
			S_P0: begin
				if (plh_q) begin
					// return address high byte
					pc_d = (dec.kind == K_RTS) ? tgt + 16'd1 : tgt;
					state_d = S_DONE;
				end else if (j0_q) begin
					lo_d = rdata;
					mreq = '{en: 1'b1, we: 1'b0, addr: {ea_q[15:8], ea_q[7:0] + 8'd1},
						wdata: 8'd0};
					state_d = S_J1;
				end else begin
					lo_d = rdata;
					mreq = '{en: 1'b1, we: 1'b0, addr: {8'd0, ea_q[7:0] + 8'd1}, wdata: 8'd0};
					state_d = S_P1;
				end
			end
			S_P1: begin
				ea_d = tgt + ((dec.am == AM_INY) ? {8'd0, y_q} : 16'd0);
				state_d = S_EA;
			end
			S_B2: begin
				state_d = S_EA;
				unique case (dec.kind)
					K_JMP: begin
						if (dec.am == AM_IND) begin
							ea_d = tgt;
							mreq = '{en: 1'b1, we: 1'b0, addr: tgt, wdata: 8'd0};
							j0_d = 1'b1;
							state_d = S_P0;
						end else begin
							pc_d = tgt;
							state_d = S_DONE;
						end
					end
					K_JSR: begin
						ea_d = tgt;
						mreq = '{en: 1'b1, we: 1'b1, addr: {STACK_PAGE, sp_q}, wdata: ret[15:8]};
						sp_d = sp_q - 8'd1;
						state_d = S_JS;
					end
					default: begin
						unique case (dec.am)
							AM_ABX:  ea_d = tgt + {8'd0, x_q};
							AM_ABY:  ea_d = tgt + {8'd0, y_q};
							default: ea_d = tgt;
						endcase
					end
				endcase
			end
			S_JS: begin
				mreq = '{en: 1'b1, we: 1'b1, addr: {STACK_PAGE, sp_q}, wdata: ret[7:0]};
				sp_d = sp_q - 8'd1;
				pc_d = ea_q;
				state_d = S_DONE;
			end
			S_J1: begin
				pc_d = tgt;
				state_d = S_DONE;
			end
			S_EA: begin
				if (dec.kind == K_ST) begin
					mreq = '{en: 1'b1, we: 1'b1, addr: ea_q,
						wdata: regsel(dec.src, a_q, x_q, y_q, sp_q)};
					state_d = S_DONE;
				end else begin
					mreq = '{en: 1'b1, we: 1'b0, addr: ea_q, wdata: 8'd0};
					state_d = S_MEM;
				end
			end
			S_MEM: begin
				p_d = arsp.p;
				if (dec.kind == K_RMW) begin
					areq.a = rdata;
					mreq = '{en: 1'b1, we: 1'b1, addr: ea_q, wdata: arsp.res};
				end else begin
					unique case (dec.dst)
						R_A: a_d = arsp.res;
						R_X: x_d = arsp.res;
						R_Y: y_d = arsp.res;
						default: ;
					endcase
				end
				state_d = S_DONE;
			end
			S_PL: begin
				state_d = S_DONE;
				unique case (dec.kind)
					K_PLA: begin
						a_d = arsp.res;
						p_d = arsp.p;
					end
					K_PLP: p_d = rdata;
					default: begin
						if (dec.kind == K_RTI) p_d = rdata;
						else lo_d = rdata;
						mreq = '{en: 1'b1, we: 1'b0, addr: {STACK_PAGE, sp_q + 8'd1},
							wdata: 8'd0};
						sp_d = sp_q + 8'd1;
						if (dec.kind == K_RTI) begin
							state_d = S_PLL;
						end else begin
							plh_d = 1'b1;
							state_d = S_PLH;
						end
					end
				endcase
			end
			S_PLL: begin
				lo_d = rdata;
				mreq = '{en: 1'b1, we: 1'b0, addr: {STACK_PAGE, sp_q + 8'd1}, wdata: 8'd0};
				sp_d = sp_q + 8'd1;
				plh_d = 1'b1;
				state_d = S_PLH;
			end
			default: begin
				// hold until the output register is free
				if (!mv_q || m_tready) begin
					load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			plh_q   <= 1'b0;
			j0_q    <= 1'b0;
			pc_q    <= 16'd0;
			a_q     <= 8'd0;
			x_q     <= 8'd0;
			y_q     <= 8'd0;
			sp_q    <= SP_RESET;
			p_q     <= P_RESET;
			mv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			plh_q   <= plh_d;
			j0_q    <= j0_d;
			pc_q    <= pc_d;
			a_q     <= a_d;
			x_q     <= x_d;
			y_q     <= y_d;
			sp_q    <= sp_d;
			p_q     <= p_d;
			if (load_out)      mv_q <= 1'b1;
			else if (m_tready) mv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		ea_q    <= ea_d;
		op_q    <= op_d;
		lo_q    <= lo_d;
		rdat_q  <= rdat_d;
		opc_q   <= opc_d;
		known_q <= known_d;
		if (load_out)
			mdata_q <= {7'd0, known_q, opc_q, rdat_q, p_q, sp_q, y_q, x_q, a_q, pc_q};
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = mdata_q;

	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, !s_tready)
	`ASSERT_SAME(a_ready_not_clearing, clk, arst_n, s_tready, !mem_busy)
	`ASSERT_NEXT(a_idle_pc_holds, clk, arst_n, (state_q == S_IDLE) && !s_tvalid,
		$stable(pc_q) && $stable(sp_q))
endmodule
`default_nettype wire
